FILE: hdl/atou_pkg.sv
// Shared types, constants and command/status structs for the ASCII-to-unsigned parser.
package atou_pkg;

  localparam int MAX_LEN = 4096;
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int VAL_W   = 32;
  localparam int CH_W    = 8;
  localparam int BASE_W  = 6;
  localparam int PROD_W  = VAL_W + BASE_W;

  localparam logic [BASE_W-1:0] RADIX_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_MIN    = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX    = BASE_W'(36);
  localparam logic [BASE_W-1:0] BASE_OCT    = BASE_W'(8);
  localparam logic [BASE_W-1:0] BASE_DEC    = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_HEX    = BASE_W'(16);
  localparam logic [BASE_W-1:0] DIGIT_NONE  = '1;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;

  typedef enum logic [2:0] {
    PH_WS,
    PH_SIGNED,
    PH_ZERO,
    PH_HEXONE,
    PH_DEC,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_WRAP,
    ACC_SAT
  } acc_op_t;

  typedef enum logic [2:0] {
    BSEL_HOLD,
    BSEL_RADIX,
    BSEL_TEN,
    BSEL_OCT,
    BSEL_HEX
  } base_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_BASE_ERR,
    RES_ACC,
    RES_HEX_PREFIX
  } res_sel_t;

  typedef struct packed {
    logic      step;
    logic      restart;
    logic      pos_inc;
    acc_op_t   acc_op;
    base_sel_t base_sel;
    logic      set_seen;
    logic      set_neg;
    logic      emit;
    res_sel_t  res_sel;
  } atou_cmd_t;

  typedef struct packed {
    logic is_space;
    logic is_plus;
    logic is_minus;
    logic is_zero;
    logic is_x;
    logic is_dec;
    logic lt_radix;
    logic lt_active;
    logic lt_oct;
    logic lt_hex;
    logic seen;
    logic radix_auto;
    logic radix_ten;
    logic radix_bad;
  } atou_status_t;

  function automatic logic [BASE_W-1:0] digit_of(input logic [CH_W-1:0] c);
    logic [BASE_W-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = BASE_W'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = BASE_W'(c - CH_LA) + BASE_DEC;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = BASE_W'(c - CH_UA) + BASE_DEC;
    end
    return d;
  endfunction

endpackage

FILE: hdl/ascii_to_unsigned_parser.sv
// Top level of the streaming ASCII-to-unsigned converter.
// Usage:
//   Feed one character per request on ch, with first high on the first
//   character of each string. Leading whitespace and one '+' are skipped,
//   then digits are accumulated in the base held by the radix register
//   (0 = auto-detect, 2..36 fixed). Write radix with radix_we while idle.
//   One result (value, end_offset, range_error, base_error) comes per
//   string, on the character that ends the number; later characters are
//   absorbed without result until the next first.
// Timing:
//   One character is taken per cycle while in_ready is high; the accumulator
//   multiply-add is combinational. The result is registered and shows on out_valid
//   the cycle after the terminating character is accepted.
//   in_ready = !out_valid || out_ready, so a waiting result blocks input
//   only while the receiver stalls; the result holds until taken.
// Reset:
//   rst (synchronous) clears the parse state and out_valid and sets the
//   radix to 10.
module ascii_to_unsigned_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        radix_we,
  input  logic [atou_pkg::BASE_W-1:0] radix,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [atou_pkg::CH_W-1:0]   ch,
  input  logic                        first,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [atou_pkg::VAL_W-1:0]  value,
  output logic [atou_pkg::POS_W-1:0]  end_offset,
  output logic                        range_error,
  output logic                        base_error
);
  import atou_pkg::*;

  atou_cmd_t    cmd;
  atou_status_t status;

  atou_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .first     (first),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  atou_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .radix_we    (radix_we),
    .radix       (radix),
    .ch          (ch),
    .cmd         (cmd),
    .status      (status),
    .value       (value),
    .end_offset  (end_offset),
    .range_error (range_error),
    .base_error  (base_error)
  );

endmodule

FILE: hdl/atou_dp.sv
// Datapath: radix register, accumulator, position counter and result register.
module atou_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          radix_we,
  input  logic [atou_pkg::BASE_W-1:0]   radix,
  input  logic [atou_pkg::CH_W-1:0]     ch,
  input  atou_pkg::atou_cmd_t           cmd,
  output atou_pkg::atou_status_t        status,
  output logic [atou_pkg::VAL_W-1:0]    value,
  output logic [atou_pkg::POS_W-1:0]    end_offset,
  output logic                          range_error,
  output logic                          base_error
);
  import atou_pkg::*;

  logic [BASE_W-1:0] cfg_radix;
  logic [VAL_W-1:0]  acc;
  logic [BASE_W-1:0] active_base;
  logic [POS_W-1:0]  pos;
  logic              seen;
  logic              neg;
  logic              ovf;

  logic [VAL_W-1:0]  acc_cur;
  logic [BASE_W-1:0] base_cur;
  logic [POS_W-1:0]  pos_cur;
  logic              seen_cur;
  logic              neg_cur;
  logic              ovf_cur;

  logic [CH_W-1:0]   c;
  logic [BASE_W-1:0] dig;
  logic [BASE_W-1:0] base_eff;
  logic [PROD_W-1:0] prod;
  logic              prod_ovf;
  logic              ovf_next;
  logic [VAL_W-1:0]  acc_next;

  // A new string starts from cleared state in the same step.
  assign acc_cur  = cmd.restart ? '0 : acc;
  assign base_cur = cmd.restart ? '0 : active_base;
  assign pos_cur  = cmd.restart ? '0 : pos;
  assign seen_cur = cmd.restart ? 1'b0 : seen;
  assign neg_cur  = cmd.restart ? 1'b0 : neg;
  assign ovf_cur  = cmd.restart ? 1'b0 : ovf;

  // Past the length limit every character reads as NUL.
  assign c   = (pos_cur >= POS_W'(MAX_LEN)) ? CH_NUL : ch;
  assign dig = digit_of(c);

  always_comb begin
    status.is_space   = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    status.is_plus    = (c == CH_PLUS);
    status.is_minus   = (c == CH_MINUS);
    status.is_zero    = (c == CH_ZERO);
    status.is_x       = (c == CH_LX) || (c == CH_UX);
    status.is_dec     = (c >= CH_ZERO) && (c <= CH_NINE);
    status.lt_radix   = (dig < cfg_radix);
    status.lt_active  = (dig < base_cur);
    status.lt_oct     = (dig < BASE_OCT);
    status.lt_hex     = (dig < BASE_HEX);
    status.seen       = seen_cur;
    status.radix_auto = (cfg_radix == '0);
    status.radix_ten  = (cfg_radix == BASE_DEC);
    status.radix_bad  = (cfg_radix != '0) && ((cfg_radix < BASE_MIN) || (cfg_radix > BASE_MAX));
  end

  always_comb begin
    case (cmd.base_sel)
      BSEL_HOLD:  base_eff = base_cur;
      BSEL_RADIX: base_eff = cfg_radix;
      BSEL_TEN:   base_eff = BASE_DEC;
      BSEL_OCT:   base_eff = BASE_OCT;
      BSEL_HEX:   base_eff = BASE_HEX;
      default:    base_eff = base_cur;
    endcase
  end

  assign prod     = PROD_W'(acc_cur) * PROD_W'(base_eff) + PROD_W'(dig);
  assign prod_ovf = (prod[PROD_W-1:VAL_W] != '0);

  always_comb begin
    ovf_next = ovf_cur;
    acc_next = acc_cur;
    case (cmd.acc_op)
      ACC_HOLD: acc_next = acc_cur;
      ACC_WRAP: acc_next = prod[VAL_W-1:0];
      ACC_SAT: begin
        ovf_next = ovf_cur | prod_ovf;
        acc_next = ovf_next ? '1 : prod[VAL_W-1:0];
      end
      default:  acc_next = acc_cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_radix <= RADIX_RESET;
    end else if (radix_we) begin
      cfg_radix <= radix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      active_base <= '0;
      pos         <= '0;
      seen        <= 1'b0;
      neg         <= 1'b0;
      ovf         <= 1'b0;
    end else if (cmd.step) begin
      acc         <= acc_next;
      active_base <= base_eff;
      pos         <= cmd.pos_inc ? pos_cur + POS_W'(1) : pos_cur;
      seen        <= seen_cur | cmd.set_seen;
      neg         <= neg_cur | cmd.set_neg;
      ovf         <= ovf_next;
    end
  end

  // Result register, loaded only on the step that ends the number.
  always_ff @(posedge clk) begin
    if (cmd.step && cmd.emit) begin
      case (cmd.res_sel)
        RES_ZERO: begin
          value       <= '0;
          end_offset  <= '0;
          range_error <= 1'b0;
          base_error  <= 1'b0;
        end
        RES_BASE_ERR: begin
          value       <= '0;
          end_offset  <= '0;
          range_error <= 1'b0;
          base_error  <= 1'b1;
        end
        RES_ACC: begin
          value       <= neg_cur ? ('0 - acc_cur) : acc_cur;
          end_offset  <= pos_cur;
          range_error <= ovf_cur;
          base_error  <= 1'b0;
        end
        RES_HEX_PREFIX: begin
          value       <= '0;
          end_offset  <= pos_cur - POS_W'(1);
          range_error <= 1'b0;
          base_error  <= 1'b0;
        end
        default: begin
          value       <= '0;
          end_offset  <= '0;
          range_error <= 1'b0;
          base_error  <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: hdl/atou_ctrl.sv
// Controller: parse phase state machine and request/result handshake.
module atou_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   first,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  atou_pkg::atou_status_t status,
  output atou_pkg::atou_cmd_t    cmd
);
  import atou_pkg::*;

  phase_t phase;
  phase_t phase_next;
  phase_t phase_cur;
  logic   out_valid_next;
  logic   accept;
  logic   do_start;
  logic   do_dec;
  logic   do_gen;
  logic   gen_ok;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign phase_cur = first ? PH_WS : phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WS;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.step     = accept;
    cmd.restart  = first;
    cmd.acc_op   = ACC_HOLD;
    cmd.base_sel = BSEL_HOLD;
    cmd.res_sel  = RES_ZERO;
    do_start     = 1'b0;
    do_dec       = 1'b0;
    do_gen       = 1'b0;
    gen_ok       = 1'b0;
    phase_next   = phase_cur;

    case (phase_cur)
      PH_WS: begin
        if (status.is_space) begin
          cmd.pos_inc = 1'b1;
        end else if (status.is_plus) begin
          cmd.pos_inc = 1'b1;
          phase_next  = PH_SIGNED;
        end else begin
          do_start = 1'b1;
        end
      end
      PH_SIGNED: do_start = 1'b1;
      PH_ZERO: begin
        if (status.is_x) begin
          cmd.base_sel = BSEL_HEX;
          cmd.pos_inc  = 1'b1;
          phase_next   = PH_HEXONE;
        end else begin
          cmd.base_sel = BSEL_OCT;
          do_gen       = 1'b1;
          gen_ok       = status.lt_oct;
        end
      end
      PH_HEXONE: begin
        if (status.lt_hex) begin
          do_gen = 1'b1;
          gen_ok = status.lt_active;
        end else begin
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_HEX_PREFIX;
          phase_next  = PH_DONE;
        end
      end
      PH_DEC: do_dec = 1'b1;
      PH_DIGITS: begin
        do_gen = 1'b1;
        gen_ok = status.lt_active;
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_DONE;
    endcase

    // First significant character: pick the base and route the character.
    if (do_start) begin
      if (status.radix_auto && status.is_zero) begin
        cmd.set_seen = 1'b1;
        cmd.pos_inc  = 1'b1;
        phase_next   = PH_ZERO;
      end else if (status.radix_bad) begin
        cmd.emit    = 1'b1;
        cmd.res_sel = RES_BASE_ERR;
        phase_next  = PH_DONE;
      end else begin
        cmd.base_sel = status.radix_auto ? BSEL_TEN : BSEL_RADIX;
        if (status.radix_auto || status.radix_ten) begin
          phase_next = PH_DEC;
          if (status.is_minus) begin
            cmd.set_neg = 1'b1;
            cmd.pos_inc = 1'b1;
          end else begin
            do_dec = 1'b1;
          end
        end else begin
          do_gen = 1'b1;
          gen_ok = status.lt_radix;
        end
      end
    end

    if (do_dec) begin
      if (status.is_dec) begin
        cmd.acc_op   = ACC_WRAP;
        cmd.set_seen = 1'b1;
        cmd.pos_inc  = 1'b1;
      end else begin
        cmd.emit    = 1'b1;
        cmd.res_sel = status.seen ? RES_ACC : RES_ZERO;
        phase_next  = PH_DONE;
      end
    end

    if (do_gen) begin
      if (gen_ok) begin
        cmd.acc_op   = ACC_SAT;
        cmd.set_seen = 1'b1;
        cmd.pos_inc  = 1'b1;
        phase_next   = PH_DIGITS;
      end else begin
        cmd.emit    = 1'b1;
        cmd.res_sel = status.seen ? RES_ACC : RES_ZERO;
        phase_next  = PH_DONE;
      end
    end

    // Hold state unless a request is taken.
    if (!accept) begin
      phase_next = phase;
    end

    out_valid_next = out_valid && !out_ready;
    if (accept && cmd.emit) begin
      out_valid_next = 1'b1;
    end
  end

endmodule

FILE: hdl/atou_checker.sv
// Port-level checker for the ASCII-to-unsigned converter, bound to the top level.
module atou_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [atou_pkg::VAL_W-1:0]  value,
  input logic [atou_pkg::POS_W-1:0]  end_offset,
  input logic                        range_error,
  input logic                        base_error
);
  import atou_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(end_offset)
      && $stable(range_error) && $stable(base_error))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  a_base_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && base_error |-> value == '0 && end_offset == '0 && !range_error)
    else $error("base error with nonzero result");

  a_range_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> value == '1)
    else $error("range error without saturated value");

  a_offset_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> end_offset <= POS_W'(MAX_LEN))
    else $error("end offset beyond length limit");

endmodule

bind ascii_to_unsigned_parser atou_checker u_atou_checker (.*);

FILE: bench/ascii_to_unsigned_parser_tb.sv
// Self-checking testbench for the streaming ASCII-to-unsigned converter.
module ascii_to_unsigned_parser_tb;
  import atou_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] end_offset;
    logic             range_error;
    logic             base_error;
  } conv_result_t;

  typedef struct packed {
    logic [BASE_W-1:0] rdx;
    logic              typed;
    conv_result_t      exp;
  } dir_row_t;

  typedef logic [CH_W-1:0] char_q_t [$];

  localparam int DIR_ROWS = 22;
  localparam int RANDOM_ITEMS = 1500;

  logic                clk;
  logic                rst = 1'b1;
  logic                radix_we = 1'b0;
  logic [BASE_W-1:0]   radix = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CH_W-1:0]     ch = '0;
  logic                first = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [VAL_W-1:0]    value;
  logic [POS_W-1:0]    end_offset;
  logic                range_error;
  logic                base_error;

  // Tag that travels with each request: use the typed-in result instead of the model.
  logic                tag_typed = 1'b0;
  conv_result_t        tag_exp = '0;

  logic                calm = 1'b0;
  int                  mismatches = 0;
  conv_result_t        pending_conversions [$];

  // Converter state mirrored by the predictor
  phase_t              p_phase;
  logic [VAL_W-1:0]    p_acc;
  logic [BASE_W-1:0]   p_base;
  logic [POS_W-1:0]    p_pos;
  logic                p_seen;
  logic                p_neg;
  logic                p_ovf;
  logic [BASE_W-1:0]   p_radix;
  conv_result_t        p_out;

  string dir_text [DIR_ROWS] = '{
    "",
    "4294967295",
    "4294967296",
    " \011\012\013\014\015-1",
    "+42x",
    "-",
    "+-5",
    "12\3776",
    "0",
    "0x1F",
    "0xg",
    "0778",
    "0X100000000",
    "-123abc",
    "-5",
    "  +FfFfFfFf",
    "zZ9",
    "101102",
    "111111111111111111111111111111111",
    "7",
    "  5",
    "\377"
  };

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{6'd10, 1'b1, '{32'h0, 13'd0, 1'b0, 1'b0}},
    '{6'd10, 1'b1, '{32'hFFFF_FFFF, 13'd10, 1'b0, 1'b0}},
    '{6'd10, 1'b1, '{32'h0, 13'd10, 1'b0, 1'b0}},
    '{6'd10, 1'b1, '{32'hFFFF_FFFF, 13'd8, 1'b0, 1'b0}},
    '{6'd10, 1'b0, '0},
    '{6'd10, 1'b0, '0},
    '{6'd10, 1'b0, '0},
    '{6'd10, 1'b0, '0},
    '{6'd0,  1'b1, '{32'h0, 13'd1, 1'b0, 1'b0}},
    '{6'd0,  1'b0, '0},
    '{6'd0,  1'b1, '{32'h0, 13'd1, 1'b0, 1'b0}},
    '{6'd0,  1'b0, '0},
    '{6'd0,  1'b1, '{32'hFFFF_FFFF, 13'd11, 1'b1, 1'b0}},
    '{6'd0,  1'b0, '0},
    '{6'd16, 1'b1, '{32'h0, 13'd0, 1'b0, 1'b0}},
    '{6'd16, 1'b0, '0},
    '{6'd36, 1'b0, '0},
    '{6'd2,  1'b0, '0},
    '{6'd2,  1'b1, '{32'hFFFF_FFFF, 13'd33, 1'b1, 1'b0}},
    '{6'd63, 1'b1, '{32'h0, 13'd0, 1'b0, 1'b1}},
    '{6'd1,  1'b1, '{32'h0, 13'd0, 1'b0, 1'b1}},
    '{6'd8,  1'b0, '0}
  };

  ascii_to_unsigned_parser DUT (
    .clk         (clk),
    .rst         (rst),
    .radix_we    (radix_we),
    .radix       (radix),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch          (ch),
    .first       (first),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .end_offset  (end_offset),
    .range_error (range_error),
    .base_error  (base_error)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int char_digit(input logic [CH_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA) + 10;
    return 99;
  endfunction

  function automatic void clear_conv();
    p_phase = PH_WS;
    p_acc   = '0;
    p_base  = '0;
    p_pos   = '0;
    p_seen  = 1'b0;
    p_neg   = 1'b0;
    p_ovf   = 1'b0;
  endfunction

  function automatic bit finish_conv(input logic [VAL_W-1:0] v, input logic [POS_W-1:0] e,
                                     input logic re, input logic be);
    p_out.value       = v;
    p_out.end_offset  = e;
    p_out.range_error = re;
    p_out.base_error  = be;
    p_phase = PH_DONE;
    return 1'b1;
  endfunction

  function automatic bit take_decimal(input logic [CH_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      p_acc  = p_acc * 32'd10 + VAL_W'(c - CH_ZERO);
      p_seen = 1'b1;
      p_pos  = p_pos + POS_W'(1);
      return 1'b0;
    end
    if (!p_seen) return finish_conv('0, '0, 1'b0, 1'b0);
    return finish_conv(p_neg ? -p_acc : p_acc, p_pos, 1'b0, 1'b0);
  endfunction

  function automatic bit take_general(input logic [CH_W-1:0] c);
    int          d;
    logic [63:0] t;
    d = char_digit(c);
    if (d < int'(p_base)) begin
      t = 64'(p_acc) * 64'(p_base) + 64'(d);
      if (p_ovf || t > 64'hFFFF_FFFF) begin
        p_ovf = 1'b1;
        p_acc = '1;
      end else begin
        p_acc = t[VAL_W-1:0];
      end
      p_seen  = 1'b1;
      p_pos   = p_pos + POS_W'(1);
      p_phase = PH_DIGITS;
      return 1'b0;
    end
    if (!p_seen) return finish_conv('0, '0, 1'b0, 1'b0);
    return finish_conv(p_acc, p_pos, p_ovf, 1'b0);
  endfunction

  function automatic bit begin_number(input logic [CH_W-1:0] c);
    logic [BASE_W-1:0] b;
    b = p_radix;
    if (b == '0) begin
      if (c == CH_ZERO) begin
        p_seen  = 1'b1;
        p_acc   = '0;
        p_pos   = p_pos + POS_W'(1);
        p_phase = PH_ZERO;
        return 1'b0;
      end
      b = BASE_DEC;
    end else if (b < BASE_MIN || b > BASE_MAX) begin
      return finish_conv('0, '0, 1'b0, 1'b1);
    end
    p_base = b;
    if (b == BASE_DEC) begin
      p_phase = PH_DEC;
      if (c == CH_MINUS) begin
        p_neg = 1'b1;
        p_pos = p_pos + POS_W'(1);
        return 1'b0;
      end
      return take_decimal(c);
    end
    p_phase = PH_DIGITS;
    return take_general(c);
  endfunction

  // Returns 1 when this character completes a conversion (result in p_out).
  function automatic bit convert_char(input logic [CH_W-1:0] c_in, input logic restart);
    logic [CH_W-1:0] c;
    c = c_in;
    if (restart) clear_conv();
    if (p_phase == PH_DONE) return 1'b0;
    if (p_pos >= POS_W'(MAX_LEN)) c = CH_NUL;
    case (p_phase)
      PH_WS: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          p_pos = p_pos + POS_W'(1);
          return 1'b0;
        end
        if (c == CH_PLUS) begin
          p_pos   = p_pos + POS_W'(1);
          p_phase = PH_SIGNED;
          return 1'b0;
        end
        return begin_number(c);
      end
      PH_SIGNED: return begin_number(c);
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          p_base  = BASE_HEX;
          p_pos   = p_pos + POS_W'(1);
          p_phase = PH_HEXONE;
          return 1'b0;
        end
        p_base = BASE_OCT;
        return take_general(c);
      end
      PH_HEXONE: begin
        if (char_digit(c) < 16) return take_general(c);
        return finish_conv('0, p_pos - POS_W'(1), 1'b0, 1'b0);
      end
      PH_DEC: return take_decimal(c);
      PH_DIGITS: return take_general(c);
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    conv_result_t e;
    if (rst) begin
      p_radix = RADIX_RESET;
      clear_conv();
    end else begin
      if (radix_we) p_radix = radix;
      if (in_valid && in_ready) begin
        if (convert_char(ch, first))
          pending_conversions.push_back(tag_typed ? tag_exp : p_out);
      end
      if (out_valid && out_ready) begin
        if (pending_conversions.size() == 0) begin
          $error("unexpected result: value %0h end_offset %0d", value, end_offset);
          mismatches++;
        end else begin
          e = pending_conversions.pop_front();
          if (value !== e.value) begin
            $error("value: expected %0h, actual %0h", e.value, value);
            mismatches++;
          end
          if (end_offset !== e.end_offset) begin
            $error("end_offset: expected %0d, actual %0d", e.end_offset, end_offset);
            mismatches++;
          end
          if (range_error !== e.range_error) begin
            $error("range_error: expected %0b, actual %0b", e.range_error, range_error);
            mismatches++;
          end
          if (base_error !== e.base_error) begin
            $error("base_error: expected %0b, actual %0b", e.base_error, base_error);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic int pick_gap(input bit quiet);
    int k;
    if (quiet) return 0;
    k = $urandom_range(0, 19);
    if (k < 10) return 0;
    if (k < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin : result_side
    int  stall;
    int  hold;
    bit  quiet;
    forever begin
      quiet = ($urandom_range(0, 7) == 0);
      stall = pick_gap(quiet);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      hold = quiet ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (hold) @(posedge clk);
    end
  end

  task automatic send_char(input logic [CH_W-1:0] c, input logic f, input logic typed,
                           input conv_result_t tv);
    int gap;
    gap = pick_gap(calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    ch        <= c;
    first     <= f;
    tag_typed <= typed;
    tag_exp   <= tv;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic feed_chars(input char_q_t s, input logic typed, input conv_result_t tv);
    foreach (s[i]) send_char(s[i], i == 0, typed, tv);
  endtask

  // Hold input until every result is out, then let the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radix(input logic [BASE_W-1:0] r);
    settle();
    radix_we <= 1'b1;
    radix    <= r;
    @(posedge clk);
    radix_we <= 1'b0;
  endtask

  task automatic make_string(input logic [BASE_W-1:0] rdx, output char_q_t s);
    int base;
    int n;
    int k;
    s = {};
    // Noise: arbitrary bytes
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) s.push_back(CH_W'($urandom));
      return;
    end
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        k = $urandom_range(0, 5);
        s.push_back(k == 0 ? CH_SPACE : CH_TAB + CH_W'(k - 1));
      end
    end
    if ($urandom_range(0, 3) == 0) s.push_back(CH_PLUS);
    if ($urandom_range(0, 5) == 0) s.push_back(CH_MINUS);
    base = int'(rdx);
    if (rdx == '0) begin
      case ($urandom_range(0, 3))
        0: begin
          s.push_back(CH_ZERO);
          s.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
          base = 16;
        end
        1: begin
          s.push_back(CH_ZERO);
          base = 8;
        end
        default: base = 10;
      endcase
    end else if (rdx < BASE_MIN || rdx > BASE_MAX) begin
      base = 36;
    end
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    repeat (n) begin
      k = $urandom_range(0, base - 1);
      if (k < 10) s.push_back(CH_ZERO + CH_W'(k));
      else s.push_back(($urandom_range(0, 1) ? CH_LA : CH_UA) + CH_W'(k - 10));
    end
    // Drop the terminator now and then so the next string restarts mid-number
    if ($urandom_range(0, 11) != 0) begin
      if ($urandom_range(0, 1)) s.push_back(CH_NUL);
      else s.push_back(CH_W'($urandom));
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) s.push_back(CH_W'($urandom));
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    logic [BASE_W-1:0] cur_radix;
    logic [BASE_W-1:0] r;
    char_q_t           chars;
    int                sent;
    int                k;
    cur_radix = RADIX_RESET;
    sent = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].rdx != cur_radix) begin
        write_radix(dir_rows[i].rdx);
        cur_radix = dir_rows[i].rdx;
      end
      chars = {};
      for (int j = 0; j < dir_text[i].len(); j++) chars.push_back(dir_text[i][j]);
      chars.push_back(CH_NUL);
      feed_chars(chars, dir_rows[i].typed, dir_rows[i].exp);
    end

    // Over-long string: the character at offset MAX_LEN acts as the terminator
    write_radix(BASE_HEX);
    chars = {};
    repeat (MAX_LEN - 1) chars.push_back(CH_SPACE);
    chars.push_back(CH_ZERO + 8'd7);
    chars.push_back(CH_ZERO);
    chars.push_back(CH_ZERO);
    chars.push_back(CH_NUL);
    feed_chars(chars, 1'b1, '{32'd7, POS_W'(MAX_LEN), 1'b0, 1'b0});

    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: r = '0;
        2: r = BASE_DEC;
        3: r = BASE_MIN;
        4: r = BASE_MAX;
        5: begin
          k = $urandom_range(36, 63);
          r = (k == 36) ? BASE_W'(1) : BASE_W'(k);
        end
        6: r = $urandom_range(0, 1) ? BASE_HEX : BASE_OCT;
        default: r = BASE_W'($urandom_range(2, 36));
      endcase
      write_radix(r);
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 10)) begin
        make_string(r, chars);
        if (chars.size() > 0) feed_chars(chars, 1'b0, '0);
        sent += chars.size();
      end
      // Close the phase with a bare terminator so a result is always owed
      chars = {};
      chars.push_back(CH_NUL);
      feed_chars(chars, 1'b0, '0);
    end

    settle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/atou_pkg.sv
hdl/atou_dp.sv
hdl/atou_ctrl.sv
hdl/ascii_to_unsigned_parser.sv
hdl/atou_checker.sv
bench/ascii_to_unsigned_parser_tb.sv
